// File: rtl/noise_source_bias_calibrator_assert.svh
// Assertion macros shared by the noise source bias calibrator RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NOISE_SOURCE_BIAS_CALIBRATOR_ASSERT_SVH
`define NOISE_SOURCE_BIAS_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nsbc_pkg.sv
// Package for the noise source bias calibrator: register map, command and
// status structs, back-end states and the window compare. No dependencies.
`default_nettype none

package nsbc_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SAMPLES   = 2'd0;
  localparam logic [1:0] REG_ACCURACY  = 2'd1;
  localparam logic [1:0] REG_START_THR = 2'd2;
  localparam logic [1:0] REG_TOLERANCE = 2'd3;

  // Reset values of the registers.
  localparam logic [23:0] SAMPLES_RESET   = 24'd1000000;
  localparam logic [22:0] ACCURACY_RESET  = 23'd15000;
  localparam logic [7:0]  START_THR_RESET = 8'd128;
  localparam logic [7:0]  TOLERANCE_RESET = 8'd2;

  // Stable round count at which calibration gives up and finishes.
  localparam logic [2:0] STABLE_LIMIT = 3'd5;

  // Division by three: x / 3 == (x * THIRD_RECIP) >> THIRD_SHIFT for 23-bit x.
  localparam logic [23:0] THIRD_RECIP = 24'd2796203;
  localparam int          THIRD_SHIFT = 23;

  typedef enum logic {
    CMD_START,
    CMD_ROUND
  } cmd_kind_e;

  // Command passed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [23:0] high;
    logic [23:0] low;
  } cmd_t;

  // Completion report from the back end to the front end.
  typedef struct packed {
    logic ack;
    logic done;
  } ack_t;

  // Configuration values seen by the back end.
  typedef struct packed {
    logic [23:0] samples;
    logic [22:0] accuracy;
    logic [7:0]  start_thr;
    logic [7:0]  tolerance;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EVAL,
    B_SCAN,
    B_DECIDE,
    B_EMIT
  } back_state_e;

  // True when half - w < c < half + w, compared without wrap-around.
  function automatic logic in_window(logic [23:0] c, logic [22:0] half, logic [22:0] w);
    logic [24:0] hw;
    logic [24:0] cw;
    hw = {2'b00, half} + {2'b00, w};
    cw = {1'b0, c} + {2'b00, w};
    return ({1'b0, c} < hw) && (cw > {2'b00, half});
  endfunction

endpackage

`default_nettype wire

// File: rtl/noise_source_bias_calibrator.sv
// Top level of the noise source bias calibrator: configuration registers,
// front end, command queue and back end. Depends on nsbc_pkg and submodules.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid_i/in_stall_o | start_req_i, sample_bit_i
//   out     | output    | out_valid_o/out_stall_i | threshold_out_o, high_total_o,
//           |           |                      | low_total_o, finished_o
//   config  | input     | APB psel/penable     | paddr, pwdata, prdata
//
// Inside a round one sample item is taken every cycle. The item that ends a round
// stalls the input while the back end steps the threshold and scans the history
// one entry per cycle, or only evaluates a count in the fine window; the stall
// ends at the emit, which waits while an older result is stalled in the output
// register. A pending result waits there while the next round counts. Reset is
// asynchronous and needs no clearing pass; the history is in flops.
`default_nettype none

module noise_source_bias_calibrator #(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Sample input.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_req_i,
  input  wire logic        sample_bit_i,
  // Round results.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       threshold_out_o,
  output logic [23:0]      high_total_o,
  output logic [23:0]      low_total_o,
  output logic             finished_o
);

  localparam int CMD_W = $bits(nsbc_pkg::cmd_t);

  nsbc_pkg::cfg_t cfg_q;
  nsbc_pkg::cmd_t push_cmd;
  nsbc_pkg::cmd_t pop_cmd;
  nsbc_pkg::ack_t ack;
  logic           push, pop, full, empty;
  logic           cfg_write;

  // Configuration registers, written at the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples   <= nsbc_pkg::SAMPLES_RESET;
      cfg_q.accuracy  <= nsbc_pkg::ACCURACY_RESET;
      cfg_q.start_thr <= nsbc_pkg::START_THR_RESET;
      cfg_q.tolerance <= nsbc_pkg::TOLERANCE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        nsbc_pkg::REG_SAMPLES:   cfg_q.samples   <= pwdata[23:0];
        nsbc_pkg::REG_ACCURACY:  cfg_q.accuracy  <= pwdata[22:0];
        nsbc_pkg::REG_START_THR: cfg_q.start_thr <= pwdata[7:0];
        nsbc_pkg::REG_TOLERANCE: cfg_q.tolerance <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      nsbc_pkg::REG_SAMPLES:   prdata = {8'd0, cfg_q.samples};
      nsbc_pkg::REG_ACCURACY:  prdata = {9'd0, cfg_q.accuracy};
      nsbc_pkg::REG_START_THR: prdata = {24'd0, cfg_q.start_thr};
      nsbc_pkg::REG_TOLERANCE: prdata = {24'd0, cfg_q.tolerance};
      default:                 prdata = '0;
    endcase
  end

  nsbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_req_i (start_req_i),
    .sample_bit_i(sample_bit_i),
    .samples_i   (cfg_q.samples),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (full),
    .ack_i       (ack)
  );

  nsbc_fifo #(
    .W(CMD_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .empty_o    (empty)
  );

  nsbc_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (pop_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .ack_o          (ack),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .threshold_out_o(threshold_out_o),
    .high_total_o   (high_total_o),
    .low_total_o    (low_total_o),
    .finished_o     (finished_o)
  );

endmodule

`default_nettype wire

// File: rtl/nsbc_fifo.sv
// Two-entry command queue between the front end and the back end.
// Generic in payload width; uses nothing from the package.
`default_nettype none

module nsbc_fifo #(
  parameter int W = 49
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      pop_data_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nsbc_front.sv
// Front end: accepts sample items, counts one round and queues start and
// round-end commands. Depends on nsbc_pkg and the assertion header.
`default_nettype none

`include "noise_source_bias_calibrator_assert.svh"

module nsbc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          start_req_i,
  input  wire logic          sample_bit_i,
  input  wire logic [23:0]   samples_i,
  output logic               push_o,
  output nsbc_pkg::cmd_t     push_cmd_o,
  input  wire logic          full_i,
  input  wire nsbc_pkg::ack_t ack_i
);

  logic        running_q, running_d;
  logic        wait_q, wait_d;
  logic [23:0] count_q, count_d;
  logic [23:0] high_q, high_d;
  logic [23:0] count_inc;
  logic [23:0] high_inc;
  logic        accept;
  logic        round_end;

  // Hold inputs while a round result is being worked out or the queue is full.
  assign in_stall_o = wait_q || full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign count_inc = count_q + 24'd1;
  assign high_inc  = high_q + {23'd0, sample_bit_i};
  assign round_end = accept && !start_req_i && running_q && (count_inc >= samples_i);

  // Counting and command generation.
  always_comb begin
    running_d  = running_q;
    wait_d     = wait_q;
    count_d    = count_q;
    high_d     = high_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: nsbc_pkg::CMD_START, high: high_inc, low: count_inc - high_inc};
    if (ack_i.ack) begin
      wait_d = 1'b0;
      if (ack_i.done) begin
        running_d = 1'b0;
      end
    end
    if (accept) begin
      if (start_req_i) begin
        running_d = 1'b1;
        count_d   = '0;
        high_d    = '0;
        push_o    = 1'b1;
      end else if (running_q) begin
        if (round_end) begin
          count_d         = '0;
          high_d          = '0;
          wait_d          = 1'b1;
          push_o          = 1'b1;
          push_cmd_o.kind = nsbc_pkg::CMD_ROUND;
        end else begin
          count_d = count_inc;
          high_d  = high_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      wait_q    <= 1'b0;
      count_q   <= '0;
      high_q    <= '0;
    end else begin
      running_q <= running_d;
      wait_q    <= wait_d;
      count_q   <= count_d;
      high_q    <= high_d;
    end
  end

  // The back end only reports on a round that the front end is waiting for.
  `NSBC_ASSERT_IMPL(a_ack_while_waiting, ack_i.ack, wait_q, "ack without pending round")
  // A command is only pushed when the queue has room.
  `NSBC_ASSERT_IMPL(a_push_has_room, push_o, !full_i, "push into full queue")
  // A round end always blocks inputs on the next cycle.
  `NSBC_ASSERT_NEXT(a_round_blocks, round_end, in_stall_o, "round end did not stall input")

endmodule

`default_nettype wire

// File: rtl/nsbc_back.sv
// Back end: applies start commands, evaluates round counts, steps the
// threshold, scans the history and emits results. Depends on nsbc_pkg.
`default_nettype none

module nsbc_back #(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire nsbc_pkg::cfg_t cfg_i,
  input  wire nsbc_pkg::cmd_t cmd_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output nsbc_pkg::ack_t      ack_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          threshold_out_o,
  output logic [23:0]         high_total_o,
  output logic [23:0]         low_total_o,
  output logic                finished_o
);

  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(HISTORY_DEPTH - 1);

  nsbc_pkg::back_state_e state_q, state_d;

  logic [7:0]    thr_q;
  logic [7:0]    hist_q [HISTORY_DEPTH];
  logic [PW-1:0] ptr_q;
  logic [PW-1:0] idx_q;
  logic [2:0]    stable_q;
  logic [7:0]    lo_q, hi_q;
  logic          coarse_q;
  logic          done_q;
  logic [23:0]   high_q, low_q;
  logic [22:0]   fine_q;
  logic [46:0]   third_prod;
  logic [22:0]   half;
  logic          fine_hit;
  logic [7:0]    thr_step;
  logic [7:0]    hist_rd;
  logic [7:0]    spread;
  logic          stable_hit;
  logic          out_valid_q;
  logic          out_free;

  // Control decoded from the state.
  logic do_start, do_take, do_eval, do_scan, do_decide, do_emit;

  // One third of the accuracy, from a reciprocal multiply, registered.
  assign third_prod = {24'd0, cfg_i.accuracy} * {23'd0, nsbc_pkg::THIRD_RECIP};
  always_ff @(posedge clk_i) begin
    fine_q <= third_prod[nsbc_pkg::THIRD_SHIFT +: 23];
  end

  assign half     = cfg_i.samples[23:1];
  assign fine_hit = nsbc_pkg::in_window(high_q, half, fine_q);
  assign hist_rd  = hist_q[idx_q];
  assign spread   = hi_q - lo_q;
  assign stable_hit = (spread <= cfg_i.tolerance);
  assign out_free = !out_valid_q || !out_stall_i;

  // Threshold step toward balance, saturating at both ends.
  always_comb begin
    thr_step = thr_q;
    if (({1'b0, high_q} < {2'b00, half}) && (thr_q != 8'd0)) begin
      thr_step = thr_q - 8'd1;
    end else if (({1'b0, high_q} > {2'b00, half}) && (thr_q != 8'hFF)) begin
      thr_step = thr_q + 8'd1;
    end
  end

  // Next state and control.
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    do_start  = 1'b0;
    do_take   = 1'b0;
    do_eval   = 1'b0;
    do_scan   = 1'b0;
    do_decide = 1'b0;
    do_emit   = 1'b0;
    unique case (state_q)
      nsbc_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == nsbc_pkg::CMD_START) begin
            do_start = 1'b1;
          end else begin
            do_take = 1'b1;
            state_d = nsbc_pkg::B_EVAL;
          end
        end
      end
      nsbc_pkg::B_EVAL: begin
        do_eval = 1'b1;
        state_d = fine_hit ? nsbc_pkg::B_EMIT : nsbc_pkg::B_SCAN;
      end
      nsbc_pkg::B_SCAN: begin
        do_scan = 1'b1;
        if (idx_q == LAST) begin
          state_d = nsbc_pkg::B_DECIDE;
        end
      end
      nsbc_pkg::B_DECIDE: begin
        do_decide = 1'b1;
        state_d   = nsbc_pkg::B_EMIT;
      end
      nsbc_pkg::B_EMIT: begin
        if (out_free) begin
          do_emit = 1'b1;
          state_d = nsbc_pkg::B_IDLE;
        end
      end
      default: state_d = nsbc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsbc_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Calibration state: threshold, history, pointer and stable round count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= nsbc_pkg::START_THR_RESET;
      ptr_q    <= '0;
      stable_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (do_start) begin
      thr_q    <= cfg_i.start_thr;
      ptr_q    <= '0;
      stable_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (do_eval && !fine_hit) begin
      thr_q         <= thr_step;
      hist_q[ptr_q] <= thr_step;
      ptr_q         <= (ptr_q == LAST) ? '0 : ptr_q + PW'(1);
    end else if (do_decide && stable_hit) begin
      stable_q <= stable_q + 3'd1;
    end
  end

  // Working registers of one round evaluation.
  always_ff @(posedge clk_i) begin
    if (do_take) begin
      high_q <= cmd_i.high;
      low_q  <= cmd_i.low;
    end
    if (do_eval) begin
      coarse_q <= nsbc_pkg::in_window(high_q, half, cfg_i.accuracy);
      done_q   <= fine_hit;
      idx_q    <= '0;
    end
    if (do_scan) begin
      if (idx_q == '0) begin
        lo_q <= hist_rd;
        hi_q <= hist_rd;
      end else begin
        if (hist_rd < lo_q) lo_q <= hist_rd;
        if (hist_rd > hi_q) hi_q <= hist_rd;
      end
      if (idx_q != LAST) begin
        idx_q <= idx_q + PW'(1);
      end
    end
    if (do_decide) begin
      done_q <= stable_hit && (coarse_q || (stable_q == nsbc_pkg::STABLE_LIMIT));
    end
  end

  // Output register; it holds a result until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      threshold_out_o <= thr_q;
      high_total_o    <= high_q;
      low_total_o     <= low_q;
      finished_o      <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ack_o       = '{ack: do_emit, done: done_q};

endmodule

`default_nettype wire
